>>> rtl/drl_pkg.sv
// Shared types and constants for the dashed line rasterizer.
// Used by every module under rtl/; depends on nothing.
package drl_pkg;

  localparam int CW   = 12;       // coordinate width
  localparam int EW   = CW + 1;   // error accumulator width
  localparam int SW   = 8;        // dash spacing / phase width
  localparam int COLW = 32;       // packed RGBA colour

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW-1:0]        delta_t;
  typedef logic [EW-1:0]        err_t;
  typedef logic [SW-1:0]        spc_t;
  typedef logic [COLW-1:0]      color_t;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  // Line parameters derived from a start beat.
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    delta_t major;
    delta_t minor;
    logic   xneg;
    logic   yneg;
    logic   xmaj;
    err_t   err;
    spc_t   phase;
    logic   active;
  } setup_t;

  // One emitted line position.
  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   visible;
    logic   last;
  } pixel_t;

  // Stepper status seen by the top level.
  typedef struct packed {
    logic active;
    logic emit;
    logic last;
  } stat_t;

endpackage

>>> rtl/drl_setup.sv
// Line setup: direction, major axis, deltas and initial error term.
// Pure combinational; depends on drl_pkg.
module drl_setup (
  input  drl_pkg::coord_t x_start,
  input  drl_pkg::coord_t y_start,
  input  drl_pkg::coord_t x_end,
  input  drl_pkg::coord_t y_end,
  input  drl_pkg::spc_t   spacing,
  output drl_pkg::setup_t setup
);
  import drl_pkg::*;

  logic   xneg, yneg, xmaj;
  delta_t dx, dy, major;

  always_comb begin
    xneg = (x_end < x_start);
    yneg = (y_end < y_start);
    // magnitude fits CW bits unsigned, so a wrapped difference is exact
    dx   = xneg ? delta_t'(x_start - x_end) : delta_t'(x_end - x_start);
    dy   = yneg ? delta_t'(y_start - y_end) : delta_t'(y_end - y_start);
    xmaj = (dx >= dy);
    major = xmaj ? dx : dy;

    setup.x0     = x_start;
    setup.y0     = y_start;
    setup.major  = major;
    setup.minor  = xmaj ? dy : dx;
    setup.xneg   = xneg;
    setup.yneg   = yneg;
    setup.xmaj   = xmaj;
    setup.err    = {2'b00, major[CW-1:1]};
    setup.phase  = (spacing == spc_t'(1)) ? spc_t'(0) : spc_t'(1);
    setup.active = (major != '0);
  end

endmodule

>>> rtl/drl_stepper.sv
// Bresenham stepper state: loads a line on start, emits one position per advance while a line is active.
// Depends on drl_pkg and takes its setup from drl_setup.
module drl_stepper (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic            command,
  input  drl_pkg::setup_t setup,
  input  drl_pkg::spc_t   spacing,
  input  drl_pkg::color_t color,
  output drl_pkg::pixel_t pix,
  output drl_pkg::stat_t  stat
);
  import drl_pkg::*;

  coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  err_t   err_r, err_nxt;
  delta_t major_r, minor_r, pos_r, pos_nxt;
  logic   xneg_r, yneg_r, xmaj_r, active_r, active_nxt;
  spc_t   phase_r, phase_nxt, spacing_r;
  color_t color_r;

  logic             start, emit, vis, fin, ge;
  err_t             sum;
  logic [EW:0]      diff;
  spc_t             ph1;

  assign start = take && (command == CMD_START);
  assign emit  = take && (command == CMD_ADVANCE) && active_r;

  always_comb begin
    vis  = (spacing_r == '0) || (phase_r >= (spacing_r >> 1));
    fin  = (pos_r == major_r);
    sum  = err_r + {1'b0, minor_r};
    diff = {1'b0, sum} - {2'b00, major_r};
    ge   = !diff[EW];
    err_nxt = ge ? diff[EW-1:0] : sum;

    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (xmaj_r || ge) begin
      cur_x_nxt = xneg_r ? cur_x_r - coord_t'(1) : cur_x_r + coord_t'(1);
    end
    if (!xmaj_r || ge) begin
      cur_y_nxt = yneg_r ? cur_y_r - coord_t'(1) : cur_y_r + coord_t'(1);
    end

    pos_nxt = pos_r + delta_t'(1);
    ph1     = phase_r + spc_t'(1);
    phase_nxt = phase_r;
    if (spacing_r != '0) begin
      phase_nxt = (ph1 >= spacing_r) ? spc_t'(0) : ph1;
    end
    active_nxt = !fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      err_r     <= '0;
      major_r   <= '0;
      minor_r   <= '0;
      xneg_r    <= 1'b0;
      yneg_r    <= 1'b0;
      xmaj_r    <= 1'b0;
      pos_r     <= '0;
      phase_r   <= '0;
      spacing_r <= '0;
      color_r   <= '0;
      active_r  <= 1'b0;
    end else if (start) begin
      cur_x_r   <= setup.x0;
      cur_y_r   <= setup.y0;
      err_r     <= setup.err;
      major_r   <= setup.major;
      minor_r   <= setup.minor;
      xneg_r    <= setup.xneg;
      yneg_r    <= setup.yneg;
      xmaj_r    <= setup.xmaj;
      pos_r     <= delta_t'(1);
      phase_r   <= setup.phase;
      spacing_r <= spacing;
      color_r   <= color;
      active_r  <= setup.active;
    end else if (emit) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      err_r    <= err_nxt;
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
    end
  end

  assign pix.x       = cur_x_r;
  assign pix.y       = cur_y_r;
  assign pix.color   = color_r;
  assign pix.visible = vis;
  assign pix.last    = fin;

  assign stat.active = active_r;
  assign stat.emit   = emit;
  assign stat.last   = fin;

endmodule

>>> rtl/drl_out_reg.sv
// Result register: holds one emitted beat until the receiver takes it.
// Depends on drl_pkg.
module drl_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  drl_pkg::pixel_t pix,
  input  logic            out_stall,
  output logic            out_valid,
  output drl_pkg::pixel_t pix_q,
  output logic            up_stall
);
  import drl_pkg::*;

  logic   valid_r, valid_nxt;
  pixel_t pix_r;

  // a full register that the receiver stalls blocks new input
  assign up_stall  = valid_r && out_stall;
  assign valid_nxt = load || up_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= pix;
    end
  end

  assign out_valid = valid_r;
  assign pix_q     = pix_r;

endmodule

>>> rtl/dashed_line_rasterizer.sv
// Dashed Bresenham line rasterizer, top level.
// Depends on drl_pkg, drl_setup, drl_stepper and drl_out_reg.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat is one command. A start
//   beat (in_command = 0) loads both endpoints, the dash spacing and the
//   colour and produces no output. An advance beat (in_command = 1)
//   produces one line position while a line is active, nothing otherwise.
//   A line of major length L gives L positions: start point first, end
//   point never; out_last marks the final one. Equal endpoints give none.
//   Output channel (out_valid / out_stall): one position per beat.
//   An advance accepted at an edge is loaded into the result register at
//   that edge and appears on the outputs right after it.
//   Throughput: one beat per clock in both directions unless stalled; the
//   line state is updated in the same cycle a beat is accepted.
//   Stall: while the result register is full and out_stall is high,
//   in_stall is raised and the held beat does not change.
//   Reset (rst_n low, synchronous): line goes idle, result register empties.
module dashed_line_rasterizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic signed [drl_pkg::CW-1:0] in_x_start,
  input  logic signed [drl_pkg::CW-1:0] in_y_start,
  input  logic signed [drl_pkg::CW-1:0] in_x_end,
  input  logic signed [drl_pkg::CW-1:0] in_y_end,
  input  logic [drl_pkg::SW-1:0]        in_dash_spacing,
  input  logic [drl_pkg::COLW-1:0]      in_line_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [drl_pkg::CW-1:0] out_pixel_x,
  output logic signed [drl_pkg::CW-1:0] out_pixel_y,
  output logic [drl_pkg::COLW-1:0]      out_pixel_color,
  output logic                          out_visible,
  output logic                          out_last
);
  import drl_pkg::*;

  setup_t setup;
  pixel_t pix, pix_q;
  stat_t  stat;
  logic   take;

  assign take = in_valid && !in_stall;

  drl_setup u_setup (
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (in_x_end),
    .y_end   (in_y_end),
    .spacing (in_dash_spacing),
    .setup   (setup)
  );

  drl_stepper u_stepper (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .command (in_command),
    .setup   (setup),
    .spacing (in_dash_spacing),
    .color   (in_line_color),
    .pix     (pix),
    .stat    (stat)
  );

  drl_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stat.emit),
    .pix       (pix),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .pix_q     (pix_q),
    .up_stall  (in_stall)
  );

  assign out_pixel_x     = pix_q.x;
  assign out_pixel_y     = pix_q.y;
  assign out_pixel_color = pix_q.color;
  assign out_visible     = pix_q.visible;
  assign out_last        = pix_q.last;

  // a beat is emitted only from an active line
  a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |-> stat.active)
    else $error("position emitted while no line is active");

  // the final position ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.emit && stat.last) |=> !stat.active)
    else $error("line still active after its last position");

  // input is blocked only behind a full result register
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  // an emitted beat always shows up on the output next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |=> out_valid)
    else $error("emitted position lost");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for dashed_line_rasterizer: drives line commands and
// checks every emitted position against a Bresenham predictor in the scoreboard.
// Depends on drl_pkg and the rasterizer RTL.
`timescale 1ns / 1ps

module tb_top;
  import drl_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_BEATS  = 150;

  typedef struct {
    cmd_t   command;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    spc_t   spacing;
    color_t color;
  } cmd_beat_t;

  // Line stepper predictor and the queue of positions it expects.
  class pixel_scoreboard;
    pixel_t expected_pixels[$];
    int     errors;
    coord_t cur_x, cur_y;
    err_t   err_acc;
    delta_t major_len, minor_len, pos_idx;
    bit     x_neg, y_neg, x_maj, drawing;
    spc_t   phase, spacing;
    color_t color;

    function new();
      errors = 0;
      cur_x = '0; cur_y = '0; err_acc = '0;
      major_len = '0; minor_len = '0; pos_idx = '0;
      x_neg = 0; y_neg = 0; x_maj = 0; drawing = 0;
      phase = '0; spacing = '0; color = '0;
    endfunction

    function coord_t step(coord_t c, bit neg);
      return neg ? coord_t'(c - 1) : coord_t'(c + 1);
    endfunction

    // Returns 1 when the beat starts a line or yields a position.
    function bit note_command(cmd_beat_t b);
      int     ax, ay, bx, by, dx, dy;
      pixel_t p;
      bit     fin;
      if (b.command == CMD_START) begin
        ax = b.xs; ay = b.ys; bx = b.xe; by = b.ye;
        x_neg = bx < ax;
        y_neg = by < ay;
        dx = x_neg ? ax - bx : bx - ax;
        dy = y_neg ? ay - by : by - ay;
        x_maj = dx >= dy;
        major_len = delta_t'(x_maj ? dx : dy);
        minor_len = delta_t'(x_maj ? dy : dx);
        err_acc = err_t'(major_len >> 1);
        cur_x = b.xs;
        cur_y = b.ys;
        spacing = b.spacing;
        color = b.color;
        pos_idx = 1;
        phase = (spacing == 1) ? spc_t'(0) : spc_t'(1);
        drawing = major_len != 0;
        return 1;
      end
      if (!drawing) return 0;
      fin = pos_idx == major_len;
      p.x = cur_x;
      p.y = cur_y;
      p.color = color;
      p.visible = (spacing == 0) || (phase >= (spacing >> 1));
      p.last = fin;
      expected_pixels.push_back(p);
      err_acc = err_t'(err_acc + minor_len);
      if (err_acc >= major_len) begin
        err_acc = err_t'(err_acc - major_len);
        if (x_maj) cur_y = step(cur_y, y_neg);
        else cur_x = step(cur_x, x_neg);
      end
      if (x_maj) cur_x = step(cur_x, x_neg);
      else cur_y = step(cur_y, y_neg);
      pos_idx = delta_t'(pos_idx + 1);
      if (spacing != 0) begin
        phase = spc_t'(phase + 1);
        if (phase >= spacing) phase = '0;
      end
      if (fin) drawing = 0;
      return 1;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_p;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected position x %0d y %0d", $time, got.x, got.y);
        errors++;
        return;
      end
      exp_p = expected_pixels.pop_front();
      if (got.x !== exp_p.x) begin
        $display("%0t: pixel_x expected %0d got %0d", $time, exp_p.x, got.x);
        errors++;
      end
      if (got.y !== exp_p.y) begin
        $display("%0t: pixel_y expected %0d got %0d", $time, exp_p.y, got.y);
        errors++;
      end
      if (got.color !== exp_p.color) begin
        $display("%0t: pixel_color expected %h got %h", $time, exp_p.color, got.color);
        errors++;
      end
      if (got.visible !== exp_p.visible) begin
        $display("%0t: visible expected %b got %b", $time, exp_p.visible, got.visible);
        errors++;
      end
      if (got.last !== exp_p.last) begin
        $display("%0t: last expected %b got %b", $time, exp_p.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic   clk = 0;
  logic   rst_n = 0;
  logic   in_valid = 0;
  logic   in_stall;
  logic   in_command = CMD_START;
  coord_t in_x_start = '0, in_y_start = '0, in_x_end = '0, in_y_end = '0;
  spc_t   in_dash_spacing = '0;
  color_t in_line_color = '0;
  logic   out_valid;
  logic   out_stall = 0;
  coord_t out_pixel_x, out_pixel_y;
  color_t out_pixel_color;
  logic   out_visible, out_last;

  pixel_scoreboard sb = new();
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int cycle_cnt = 0;
  int useful_beats = 0;

  dashed_line_rasterizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end),
    .in_dash_spacing(in_dash_spacing), .in_line_color(in_line_color),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_pixel_color(out_pixel_color), .out_visible(out_visible), .out_last(out_last)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = HOLD_CYCLES - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x = out_pixel_x;
      got.y = out_pixel_y;
      got.color = out_pixel_color;
      got.visible = out_visible;
      got.last = out_last;
      sb.check_pixel(got);
    end
  end

  task automatic send_beat(cmd_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_command <= b.command;
    in_x_start <= b.xs;
    in_y_start <= b.ys;
    in_x_end <= b.xe;
    in_y_end <= b.ye;
    in_dash_spacing <= b.spacing;
    in_line_color <= b.color;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (sb.note_command(b)) useful_beats++;
  endtask

  function automatic cmd_beat_t noise_beat();
    cmd_beat_t b;
    b.command = cmd_t'($urandom_range(1));
    b.xs = coord_t'($urandom);
    b.ys = coord_t'($urandom);
    b.xe = coord_t'($urandom);
    b.ye = coord_t'($urandom);
    b.spacing = spc_t'($urandom);
    b.color = $urandom;
    return b;
  endfunction

  // Start a line, then advance through it; extra > 0 adds idle advances,
  // extra < 0 abandons the line early.
  task automatic run_line(int xs, int ys, int xe, int ye, int sp, color_t col, int extra);
    cmd_beat_t b;
    int dx, dy, n;
    b = noise_beat();
    b.command = CMD_START;
    b.xs = coord_t'(xs); b.ys = coord_t'(ys);
    b.xe = coord_t'(xe); b.ye = coord_t'(ye);
    b.spacing = spc_t'(sp);
    b.color = col;
    send_beat(b);
    dx = (xe > xs) ? xe - xs : xs - xe;
    dy = (ye > ys) ? ye - ys : ys - ye;
    n = ((dx > dy) ? dx : dy) + extra;
    for (int i = 0; i < n; i++) begin
      b = noise_beat();
      b.command = CMD_ADVANCE;
      send_beat(b);
    end
  endtask

  function automatic int end_coord(int s, int d);
    if (s + d > 2047 || s + d < -2048) return s - d;
    return s + d;
  endfunction

  function automatic int pick_spacing();
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return $urandom_range(2, 3);
      3: return $urandom_range(4, 16);
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic random_line(int max_len);
    int xs, ys, dx, dy, extra;
    xs = $urandom_range(4095) - 2048;
    ys = $urandom_range(4095) - 2048;
    dx = $urandom_range(2 * max_len) - max_len;
    dy = $urandom_range(2 * max_len) - max_len;
    if ($urandom_range(19) == 0) begin
      dx = 0;
      dy = 0;
    end
    case ($urandom_range(9))
      0: extra = $urandom_range(1, 3);
      1: extra = -$urandom_range(1, 4);
      default: extra = 0;
    endcase
    run_line(xs, ys, end_coord(xs, dx), end_coord(ys, dy), pick_spacing(), $urandom, extra);
  endtask

  task automatic random_phase(int snd_pct, int rcv_pct, bit squeeze);
    int goal;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    goal = useful_beats + PHASE_BEATS;
    if (squeeze) begin
      hold_req = 1;
      run_line(-100, 50, -60, 20, 3, $urandom, 0);
    end
    while (useful_beats < goal) begin
      if ($urandom_range(9) == 0) send_beat(noise_beat());
      else random_line(($urandom_range(3) == 0) ? 60 : 12);
    end
  endtask

  initial begin
    cmd_beat_t b;
    repeat (5) @(negedge clk);
    rst_n <= 1;

    snd_idle_pct = 17;
    rcv_idle_pct = 59;
    // advance while idle, zero-length line, extreme endpoints and colors,
    // restart while active, spacing of one, both step directions
    b = noise_beat();
    b.command = CMD_ADVANCE;
    send_beat(b);
    run_line(3, 3, 3, 3, 5, $urandom, 1);
    run_line(-2048, -2048, 2047, 2047, 255, '1, -4092);
    run_line(2047, -2048, -2048, 2047, 0, '0, -4092);
    run_line(0, 0, 3, -5, 1, 32'h12345678, 1);
    run_line(5, 2, -2, 1, 2, 32'h80000001, 0);

    random_phase(17, 59, 0);
    random_phase(59, 17, 0);
    random_phase(0, 0, 1);

    @(negedge clk);
    in_valid <= 0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
